@@ rtl/lil_pkg.sv @@
// Package for the leaky integrator ladder: widths, register indexes, types.
// No dependencies.
package lil_pkg;

    localparam int STAGES     = 7;
    localparam int CHANNELS   = 64;
    localparam int CH_W       = 6;
    localparam int TAP_W      = 3;
    localparam int SAMPLE_W   = 16;
    localparam int LOG_W      = 16;
    localparam int DEPTH      = CHANNELS * STAGES;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int STG_W      = $clog2(STAGES);
    localparam int NUM_DECAY  = 7;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_LOG_FLOOR = 3'd7;
    localparam logic [16:0] LN2_Q16 = 17'd45426;
    localparam int LN_65536_Q11 = 22713;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_RUN,
        ST_LOG,
        ST_OUT
    } state_t;

    // Phases of the iterative log unit.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SQUARE,
        PH_SCALE,
        PH_ROUND
    } log_ph_t;

    // One stage step handed from cell to cell.
    typedef struct packed {
        logic        valid;
        logic [15:0] decay;
        logic [15:0] state;
        logic [15:0] prev;
    } cell_in_t;

endpackage

@@ rtl/lil_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
module lil_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ rtl/lil_cell.sv @@
// One leaky integrator step, registered: s = (a*s + (1-a)*prev + half) >> 16.
// Depends on lil_pkg.
module lil_cell
    import lil_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cell_in_t    cin,
    output logic        out_valid,
    output logic [15:0] out_state
);
    logic [33:0] acc;
    logic [16:0] gain;
    logic        valid_reg;
    logic [15:0] state_reg;

    always_comb
    begin
        gain = 17'h10000 - {1'b0, cin.decay};
        acc  = {18'd0, cin.decay} * {18'd0, cin.state}
             + {17'd0, gain} * {18'd0, cin.prev} + 34'd32768;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= cin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= acc[31:16];
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;
endmodule

@@ rtl/lil_log.sv @@
// Iterative natural log in Q4.11: one squaring step per cycle, then scaling and a saturating round.
// Depends on lil_pkg.
module lil_log
    import lil_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [16:0]             x,
    output logic                    done,
    output logic signed [LOG_W-1:0] result
);
    logic [4:0]  cnt_reg, cnt_next;
    log_ph_t     ph_reg, ph_next;
    logic [17:0] m_reg, m_next;
    logic [15:0] frac_reg, frac_next;
    logic [4:0]  e_reg, e_next;
    logic        zero_reg, zero_next;
    logic [38:0] q_reg, q_next;
    logic signed [LOG_W-1:0] res_reg, res_next;
    logic        done_reg, done_next;
    logic [35:0] sq;
    logic [4:0]  e_c;
    logic signed [20:0] r;

    always_comb
    begin
        e_c = 5'd0;
        for (int i = 0; i < 17; i++)
        begin
            if (x[i])
            begin
                e_c = 5'(i);
            end
        end
        sq = {18'd0, m_reg} * {18'd0, m_reg};
        r  = $signed({1'b0, 19'((q_reg + 39'd1048576) >> 21)}) - 21'sd22713;
    end

    always_comb
    begin
        cnt_next = cnt_reg; ph_next = ph_reg; m_next = m_reg; frac_next = frac_reg;
        e_next = e_reg; zero_next = zero_reg; q_next = q_reg; res_next = res_reg;
        done_next = 1'b0;
        case (ph_reg)
            PH_IDLE:
            begin
                if (start)
                begin
                    e_next = e_c; zero_next = (x == 17'd0);
                    m_next = 18'({1'b0, x} << (5'd16 - e_c));
                    frac_next = 16'd0; cnt_next = 5'd0; ph_next = PH_SQUARE;
                end
            end
            PH_SQUARE:
            begin
                if (sq[33])
                begin
                    m_next = sq[34:17]; frac_next = {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    m_next = sq[33:16]; frac_next = {frac_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                begin
                    ph_next = PH_SCALE;
                end
            end
            PH_SCALE:
            begin
                q_next = {18'd0, e_reg, frac_reg} * {22'd0, LN2_Q16};
                ph_next = PH_ROUND;
            end
            default:
            begin
                if (zero_reg || r < -21'sd32768)
                begin
                    res_next = -16'sd32768;
                end
                else if (r > 21'sd32767)
                begin
                    res_next = 16'sd32767;
                end
                else
                begin
                    res_next = r[15:0];
                end
                done_next = 1'b1; ph_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg <= PH_IDLE; done_reg <= 1'b0; cnt_reg <= 5'd0;
        end
        else
        begin
            ph_reg <= ph_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg <= m_next; frac_reg <= frac_next; e_reg <= e_next;
        zero_reg <= zero_next; q_reg <= q_next; res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule

@@ rtl/leaky_integrator_ladder_log.sv @@
// Top level of the leaky integrator ladder with log outputs.
// Depends on lil_pkg, lil_ram, lil_cell and lil_log.
//
// Each accepted word (channel, sample) runs the channel's ladder of STAGES
// integrators through a row of STAGES cells, one cell per stage; each cell
// reads its stage from its own RAM while the previous stage's new value
// ripples along the row one cell per cycle. The block then works out
// STAGES logarithms in a shared iterative log unit (sixteen squaring steps
// plus scaling and rounding) and sends them as taps STAGES-2 down to 0 and
// then the raw sample's log on tap STAGES-1 with tlast set. Per sample the
// block accepts the word and reads the RAMs, ripples the row, then for each
// tap runs the log unit and presents the result. While m_tready is low a
// waiting tap stalls the block, and no new word is accepted until the last
// tap has left. After reset a clearing pass writes zero into all CHANNELS
// entries of every stage RAM, during which no word is accepted. Channels at
// or above CHANNELS are dropped with no output.
module leaky_integrator_ladder_log
    import lil_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // channel[5:0], sample[21:6], zero fill
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // out_channel[5:0], tap[8:6], log_value[24:9]
    output logic                 m_tlast
);
    localparam int RAM_AW = $clog2(CHANNELS);

    state_t state_reg, state_next;
    logic [15:0] decay_reg [NUM_DECAY];
    logic [7:0]  floor_reg;
    logic [RAM_AW-1:0] clr_reg, clr_next;
    logic [CH_W-1:0]   ch_reg;
    logic [15:0]       sample_reg;
    logic [15:0]       vals_reg [STAGES];
    logic [STG_W-1:0]  idx_reg, idx_next;
    logic              lstart;
    logic [16:0]       lx;
    logic              ldone;
    logic signed [LOG_W-1:0] lres;
    logic signed [LOG_W-1:0] out_log_reg;
    logic [TAP_W-1:0]  out_tap_reg;
    logic              out_last_reg;
    logic              accept;

    logic [15:0] rd [STAGES];
    logic        cv [STAGES];
    logic [15:0] cs [STAGES];

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_DECAY; k++)
            begin
                decay_reg[k] <= 16'd32768;
            end
            floor_reg <= 8'd1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_LOG_FLOOR)
            begin
                floor_reg <= cfg_data[7:0];
            end
            else
            begin
                decay_reg[cfg_index] <= cfg_data;
            end
        end
    end

    // Row of cells; cell k takes its prev from cell k-1 (or the sample).
    // The RAMs read the incoming channel at the accepting edge so that the
    // first cell finds its stored stage ready in the cycle after.
    for (genvar k = 0; k < STAGES; k++)
    begin : g_cell
        cell_in_t    ci;
        logic        we;
        logic        pv;
        logic [15:0] pp;
        if (k == 0)
        begin : g_head
            assign pv = (state_reg == ST_READ);
            assign pp = sample_reg;
        end
        else
        begin : g_link
            assign pv = cv[k-1];
            assign pp = cs[k-1];
        end
        assign ci = '{valid: pv, decay: decay_reg[k], state: rd[k], prev: pp};
        assign we = (state_reg == ST_CLEAR) || cv[k];
        lil_ram #(.WIDTH(16), .DEPTH(CHANNELS)) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr ((state_reg == ST_CLEAR) ? clr_reg : ch_reg[RAM_AW-1:0]),
            .wdata ((state_reg == ST_CLEAR) ? 16'd0 : cs[k]),
            .raddr (accept ? s_tdata[RAM_AW-1:0] : ch_reg[RAM_AW-1:0]),
            .rdata (rd[k])
        );
        lil_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cin       (ci),
            .out_valid (cv[k]),
            .out_state (cs[k])
        );
        always_ff @(posedge clk)
        begin
            if (cv[k])
            begin
                vals_reg[k] <= cs[k];
            end
        end
    end

    // The log operand follows the tap index that the start pulse begins.
    always_comb
    begin
        if (idx_next == STG_W'(STAGES - 1))
        begin
            lx = {1'b0, sample_reg} + {9'd0, floor_reg};
        end
        else
        begin
            lx = {1'b0, vals_reg[idx_next + STG_W'(1)]} + {9'd0, floor_reg};
        end
    end

    lil_log u_log (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (lstart),
        .x      (lx),
        .done   (ldone),
        .result (lres)
    );

    always_comb
    begin
        state_next = state_reg; clr_next = clr_reg; idx_next = idx_reg;
        lstart = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + RAM_AW'(1);
                if (clr_reg == RAM_AW'(CHANNELS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && (32'(s_tdata[5:0]) < CHANNELS))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (cv[STAGES-1])
                begin
                    state_next = ST_LOG; idx_next = '0; lstart = 1'b1;
                end
            end
            ST_LOG:
            begin
                if (ldone)
                begin
                    state_next = ST_OUT;
                end
            end
            default:
            begin
                if (m_tready)
                begin
                    if (idx_reg == STG_W'(STAGES - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + STG_W'(1); lstart = 1'b1;
                        state_next = ST_LOG;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR; clr_reg <= '0; idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next; clr_reg <= clr_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg <= s_tdata[5:0]; sample_reg <= s_tdata[21:6];
        end
        if (ldone)
        begin
            out_log_reg  <= lres;
            out_last_reg <= (idx_reg == STG_W'(STAGES - 1));
            out_tap_reg  <= (idx_reg == STG_W'(STAGES - 1)) ? TAP_W'(STAGES - 1)
                          : TAP_W'(STAGES - 2) - TAP_W'(idx_reg);
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {7'd0, out_log_reg, out_tap_reg, ch_reg};

`ifndef SYNTHESIS
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready) else $error("ready while busy");
    a_row_done: assert property (@(posedge clk) disable iff (!rst_n)
        cv[STAGES-1] |-> (state_reg == ST_RUN)) else $error("row finished out of step");
    a_log_done: assert property (@(posedge clk) disable iff (!rst_n)
        ldone |-> (state_reg == ST_LOG)) else $error("log result unexpected");
`endif
endmodule

@@ tb/sv/tb.sv @@
// Self-checking testbench for leaky_integrator_ladder_log.
// Depends on lil_pkg and the RTL of the block; predicts every log word itself.
module tb
    import lil_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // One result word as the block should send it.
    typedef struct {
        logic [5:0]  ch;
        logic [2:0]  tap;
        logic [15:0] logv;
        logic        last;
    } tap_word_t;

    // One pending input word.
    typedef struct {
        logic [5:0]  ch;
        logic [15:0] sample;
    } sample_word_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [23:0]          s_tdata;   // channel[5:0], sample[21:6], zero fill
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;   // out_channel[5:0], tap[8:6], log_value[24:9]
    logic                 m_tlast;

    leaky_integrator_ladder_log u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Predictor state: its own copy of the decays, the floor and the ladders.
    logic [15:0]  decay_q[NUM_DECAY];
    logic [7:0]   floor_q;
    logic [15:0]  ladder_q[CHANNELS][STAGES];

    sample_word_t pending_samples[$];
    tap_word_t    expected_taps[$];

    int  errors;
    int  words_sent;
    int  words_seen;
    int  stall_cycles;
    int  idle_count;
    bit  calm;          // last part of the run: no idling on either side
    bit  hold_rx;       // long receiver hold-off requested
    bit  done;

    always #5 clk = ~clk;

    // Natural log of x in Q4.11, from log2 by repeated squaring.
    function automatic logic [15:0] ln_q411(input logic [16:0] x);
        int unsigned e;
        logic [63:0] m;
        logic [15:0] frac;
        logic [63:0] q;
        longint r;
        e = 0;
        frac = '0;
        if (x == 0)
            return 16'h8000;
        while (e < 16 && (x >> (e + 1)) != 0)
            e++;
        m = 64'(x) << (16 - e);
        for (int i = 0; i < 16; i++)
        begin
            m = (m * m) >> 16;
            frac = frac << 1;
            if (m >= 64'd131072)
            begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        q = (64'(e) * 64'd65536 + 64'(frac)) * 64'd45426;
        r = longint'((q + 64'd1048576) >> 21) - 22713;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    function automatic logic [15:0] smooth(input logic [15:0] a, input logic [15:0] s,
                                           input logic [15:0] prev);
        logic [63:0] acc;
        acc = 64'(a) * 64'(s) + (64'd65536 - 64'(a)) * 64'(prev) + 64'd32768;
        acc = acc >> 16;
        if (acc > 64'd65535)
            acc = 64'd65535;
        return acc[15:0];
    endfunction

    // Runs the channel's ladder and queues the STAGES words it must produce.
    task automatic predict_taps(input sample_word_t w);
        logic [15:0] prev;
        tap_word_t   t;
        prev = smooth(decay_q[0], ladder_q[w.ch][0], w.sample);
        ladder_q[w.ch][0] = prev;
        for (int k = 1; k < STAGES; k++)
        begin
            prev = smooth(decay_q[k], ladder_q[w.ch][k], prev);
            ladder_q[w.ch][k] = prev;
            t.ch = w.ch;
            t.tap = 3'(STAGES - 1 - k);
            t.logv = ln_q411(17'(prev) + 17'(floor_q));
            t.last = 1'b0;
            expected_taps.insert(expected_taps.size(), t);
        end
        t.ch = w.ch;
        t.tap = 3'(STAGES - 1);
        t.logv = ln_q411(17'(w.sample) + 17'(floor_q));
        t.last = 1'b1;
        expected_taps.insert(expected_taps.size(), t);
    endtask

    // Driver: offers the oldest pending word, with random gaps. The
    // prediction is made at the edge where the word is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            idle_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_taps(pending_samples.pop_front());
                words_sent++;
            end
            if (!(s_tvalid && s_tready) && s_tvalid)
            begin
                // Word still on offer: hold it.
            end
            else if (idle_count > 0)
            begin
                idle_count--;
                s_tvalid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                idle_count = $urandom_range(1, 11) - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b00, pending_samples[0].sample, pending_samples[0].ch};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Monitor: takes each accepted word, compares it to the oldest prediction,
    // and drives tready with random stalls and the long hold-off.
    int rx_idle;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_idle = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                tap_word_t exp_w;
                words_seen++;
                if (expected_taps.size() == 0)
                begin
                    $display("%0t: unexpected word %h last %b", $time, m_tdata, m_tlast);
                    errors++;
                end
                else
                begin
                    exp_w = expected_taps.pop_front();
                    if (m_tdata[5:0] != exp_w.ch || m_tdata[8:6] != exp_w.tap ||
                        m_tdata[24:9] != exp_w.logv || m_tlast != exp_w.last ||
                        m_tdata[31:25] != '0)
                    begin
                        $display("%0t: mismatch expected ch %0d tap %0d log %h last %b",
                                 $time, exp_w.ch, exp_w.tap, exp_w.logv, exp_w.last);
                        $display("%0t:          actual   ch %0d tap %0d log %h last %b",
                                 $time, m_tdata[5:0], m_tdata[8:6], m_tdata[24:9], m_tlast);
                        errors++;
                    end
                end
            end
            if (hold_rx)
                m_tready <= 1'b0;
            else if (rx_idle > 0)
            begin
                rx_idle--;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                rx_idle = $urandom_range(1, 11) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog: cycles with no accepted word on either side.
    always @(posedge clk)
    begin
        if (rst_n && !done)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            // Allow the long receiver hold-off and the clearing pass several times
            // over.
            if (stall_cycles > 3000)
            begin
                $display("%0t: watchdog expired, %0d words still expected",
                         $time, expected_taps.size());
                $display("tb failed");
                $finish;
            end
        end
    end

    // Register writes happen only with the block idle; the edge order is safe
    // because the write signals are driven by nonblocking assignments, so the block never samples them mid-change.
    task automatic write_reg(input int idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx < NUM_DECAY)
            decay_q[idx] = val;
        else if (CFG_IDX_W'(idx) == REG_LOG_FLOOR)
            floor_q = val[7:0];
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || expected_taps.size() > 0 || s_tvalid)
            @(posedge clk);
        // Let the block settle before touching its registers.
        repeat (20) @(posedge clk);
    endtask

    task automatic push_sample(input int ch, input int smp);
        sample_word_t w;
        w.ch = 6'(ch);
        w.sample = 16'(smp);
        pending_samples.insert(pending_samples.size(), w);
    endtask

    // Most random words go to a few channels so the ladders build up state.
    task automatic random_phase(input int n);
        for (int i = 0; i < n; i++)
        begin
            int ch;
            int smp;
            ch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 3);
            case ($urandom_range(0, 5))
                0: smp = 0;
                1: smp = 65535;
                2: smp = $urandom_range(0, 255);
                default: smp = $urandom_range(0, 65535);
            endcase
            push_sample(ch, smp);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        words_sent = 0;
        words_seen = 0;
        stall_cycles = 0;
        calm = 1'b0;
        hold_rx = 1'b0;
        done = 1'b0;
        for (int k = 0; k < NUM_DECAY; k++)
            decay_q[k] = 16'd32768;
        floor_q = 8'd1;
        for (int c = 0; c < CHANNELS; c++)
            for (int k = 0; k < STAGES; k++)
                ladder_q[c][k] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset values: extremes of channel and sample.
        push_sample(0, 0);
        push_sample(63, 65535);
        push_sample(0, 65535);
        push_sample(63, 0);
        push_sample(21, 16'h5555);
        push_sample(42, 16'hAAAA);
        push_sample(1, 1);
        drain();

        // Floor extremes and decay extremes.
        write_reg(REG_LOG_FLOOR, 16'd255);
        for (int k = 0; k < NUM_DECAY; k++)
            write_reg(k, 16'd0);
        push_sample(5, 65535);
        push_sample(5, 0);
        push_sample(6, 65535);
        drain();
        for (int k = 0; k < NUM_DECAY; k++)
            write_reg(k, 16'd65535);
        write_reg(REG_LOG_FLOOR, 16'd1);
        push_sample(5, 65535);
        push_sample(5, 0);
        push_sample(7, 12345);
        drain();

        // Random phases, each with its own decays and floor.
        for (int p = 0; p < 4; p++)
        begin
            for (int k = 0; k < NUM_DECAY; k++)
                write_reg(k, 16'($urandom_range(0, 65535)));
            write_reg(REG_LOG_FLOOR, 16'($urandom_range(1, 255)));
            random_phase(90);
            if (p == 1)
            begin
                // Receiver holds off while the sender keeps offering words.
                wait (words_sent > 170);
                hold_rx = 1'b1;
                repeat (400) @(posedge clk);
                hold_rx = 1'b0;
            end
            if (p == 3)
            begin
                wait (pending_samples.size() < 30);
                calm = 1'b1;
            end
            drain();
        end

        done = 1'b1;
        $display("Covered %0d samples and %0d tap words over seven register settings,",
                 words_sent, words_seen);
        $display("including decay and floor extremes and a long output stall.");
        if (errors == 0 && expected_taps.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
